[rtl/mips_itype_execute_assert.svh]
// Assertion macros shared by the checker of the I-type execute block.
`ifndef MIPS_ITYPE_EXECUTE_ASSERT_SVH
`define MIPS_ITYPE_EXECUTE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MIE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mipsie_pkg.sv]
package mipsie_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam logic [31:0] MEM_BASE_RST  = 32'h0040_0000;

  typedef enum logic [5:0] {
    OP_REGIMM = 6'h01,
    OP_BEQ    = 6'h04,
    OP_BNE    = 6'h05,
    OP_BLEZ   = 6'h06,
    OP_BGTZ   = 6'h07,
    OP_ADDI   = 6'h08,
    OP_ADDIU  = 6'h09,
    OP_SLTI   = 6'h0A,
    OP_SLTIU  = 6'h0B,
    OP_ANDI   = 6'h0C,
    OP_ORI    = 6'h0D,
    OP_XORI   = 6'h0E,
    OP_LUI    = 6'h0F,
    OP_LB     = 6'h20,
    OP_LH     = 6'h21,
    OP_LW     = 6'h23,
    OP_LBU    = 6'h24,
    OP_LHU    = 6'h25,
    OP_SB     = 6'h28,
    OP_SH     = 6'h29,
    OP_SW     = 6'h2B
  } opcode_e;

  // REGIMM selects the branch condition through the rt field.
  localparam logic [4:0] RT_BLTZ = 5'd0;
  localparam logic [4:0] RT_BGEZ = 5'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADOP   = 2'd1,
    ST_BADADDR = 2'd2
  } status_e;

endpackage

[rtl/mips_itype_execute.sv]
// Pipeline: an accepted instruction word moves through stages 1, 2 and 3 into the output
// register. Throughput: one instruction per cycle while the output is not stalled; an
// instruction that reads the rt of a load directly ahead of it waits in stage 1 until the
// load data has left the memory banks. Reset: control and register file valid bits clear,
// mem_base takes MEM_BASE_RST at once; then a clearing pass writes zeros to all ROWS rows
// of the data banks, one row per cycle, and no instruction is accepted while it runs.
module mips_itype_execute #(
  parameter int unsigned MEM_BYTES = mipsie_pkg::MEM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // instr_word [31:0], cur_pc [63:32]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc [31:0], reg_written [32], dest_index [37:33], dest_value [69:38],
  // mem_written [70], status [72:71], zero [79:73]
  output logic [79:0] m_axis_tdata
);

  localparam int unsigned ROWS     = (MEM_BYTES + 3) / 4;
  localparam int unsigned RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [31:0] LIM_BYTE = 32'(MEM_BYTES - 1);
  localparam logic [31:0] LIM_HALF = 32'(MEM_BYTES - 2);
  localparam logic [31:0] LIM_WORD = 32'(MEM_BYTES - 4);

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Configuration and clearing pass
  logic [31:0]   mem_base_q;
  logic          clr_q;
  logic [RW-1:0] clr_row_q;

  // Handshake and stage control
  logic in_acc, s1_adv, s2_adv, out_adv, s3_free, s2_free, s1_free, hazard;
  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;

  // Register file
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic        wb_vld_q;
  logic [4:0]  wb_idx_q;
  logic [31:0] wb_val_q;

  // Stage 1
  logic [31:0] s1_iw_q, s1_pc_q, s1_target_q, s1_disp_q;
  logic [31:0] s1_rfa_q, s1_rfb_q, s1_a_q, s1_b_q;
  logic        s1_rfva_q, s1_rfvb_q, s1_fresh_q;
  logic [4:0]  s1_rs, s1_rt;
  logic [15:0] s1_imm;
  logic [31:0] s1_simm, s1_zimm, res_a, res_b, s1_alu, s1_off, s1_npc;
  logic        s1_wr, s1_taken, s1_badop, s1_ld, s1_st, s1_sgn;
  logic [1:0]  s1_sz;

  // Stage 2
  logic [4:0]  s2_rt_q;
  logic [31:0] s2_alu_q, s2_off_q, s2_b_q, s2_npc_q;
  logic        s2_wr_q, s2_ld_q, s2_st_q, s2_sgn_q, s2_badop_q;
  logic [1:0]  s2_sz_q;
  logic        s2_in_range;
  logic [1:0]  s2_lo;
  logic [RW-1:0] s2_row, s2_row_inc;
  logic [RW-1:0] bank_row [4];
  logic [RW-1:0] bank_waddr [4];
  logic [7:0]    bank_wdata [4];
  logic [3:0]    bank_we;
  logic [7:0]    rd_q [4];

  // Stage 3
  logic [4:0]  s3_rt_q;
  logic [31:0] s3_alu_q, s3_npc_q;
  logic        s3_wr_q, s3_ld_q, s3_mw_q, s3_sgn_q;
  logic [1:0]  s3_sz_q, s3_lo_q;
  mipsie_pkg::status_e s3_status_q;
  logic [31:0] s3_word, s3_ldv, s3_val;

  // Output register
  logic [31:0] out_npc_q, out_val_q;
  logic        out_wr_q, out_mw_q;
  logic [4:0]  out_idx_q;
  mipsie_pkg::status_e out_status_q;

  // ------------------------------------------------------------------
  // Flow control
  assign out_adv = s3_vld_q && (!out_vld_q || m_axis_tready);
  assign s3_free = !s3_vld_q || out_adv;
  assign s2_adv  = s2_vld_q && s3_free;
  assign s2_free = !s2_vld_q || s2_adv;
  // Load data is not ready until stage 3, so a dependent word waits in stage 1 while the load is in stage 2.
  assign hazard  = s1_vld_q && s2_vld_q && s2_ld_q && (s2_rt_q != 5'd0) &&
                   ((s2_rt_q == s1_rs) || (s2_rt_q == s1_rt));
  assign s1_adv  = s1_vld_q && s2_free && !hazard;
  assign s1_free = !s1_vld_q || s1_adv;
  assign s_axis_tready = s1_free && !clr_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_base_q <= mipsie_pkg::MEM_BASE_RST;
      clr_q      <= 1'b1;
      clr_row_q  <= '0;
      s1_vld_q   <= 1'b0;
      s1_fresh_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      rf_vld_q   <= '0;
      wb_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mem_base_q <= cfg_wdata_i;
      end
      if (clr_q) begin
        clr_row_q <= clr_row_q + RW'(1);
        if (clr_row_q == ROW_LAST) begin
          clr_q <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_vld_q   <= 1'b1;
        s1_fresh_q <= 1'b1;
      end else begin
        if (s1_adv) begin
          s1_vld_q <= 1'b0;
        end
        s1_fresh_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_q <= 1'b1;
      end else if (s2_adv) begin
        s2_vld_q <= 1'b0;
      end
      if (s2_adv) begin
        s3_vld_q <= 1'b1;
      end else if (out_adv) begin
        s3_vld_q <= 1'b0;
      end
      if (out_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (out_adv && s3_wr_q) begin
        rf_vld_q[s3_rt_q] <= 1'b1;
        wb_vld_q          <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Register file: read at acceptance, written when a word retires.
  always_ff @(posedge clk_i) begin
    if (out_adv && s3_wr_q) begin
      rf_mem[s3_rt_q] <= s3_val;
      wb_idx_q        <= s3_rt_q;
      wb_val_q        <= s3_val;
    end
    if (in_acc) begin
      s1_rfa_q  <= rf_mem[s_axis_tdata[25:21]];
      s1_rfb_q  <= rf_mem[s_axis_tdata[20:16]];
      s1_rfva_q <= rf_vld_q[s_axis_tdata[25:21]];
      s1_rfvb_q <= rf_vld_q[s_axis_tdata[20:16]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_iw_q     <= s_axis_tdata[31:0];
      s1_pc_q     <= s_axis_tdata[63:32];
      s1_target_q <= s_axis_tdata[63:32] +
                     {{14{s_axis_tdata[15]}}, s_axis_tdata[15:0], 2'b00};
      s1_disp_q   <= {{16{s_axis_tdata[15]}}, s_axis_tdata[15:0]} - mem_base_q;
    end else if (s1_vld_q && !s1_adv) begin
      // A waiting word keeps its operands up to date with every write it sees.
      s1_a_q <= res_a;
      s1_b_q <= res_b;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: operand forwarding, decode, ALU, branch and address add
  assign s1_rs   = s1_iw_q[25:21];
  assign s1_rt   = s1_iw_q[20:16];
  assign s1_imm  = s1_iw_q[15:0];
  assign s1_simm = {{16{s1_imm[15]}}, s1_imm};
  assign s1_zimm = {16'h0000, s1_imm};

  always_comb begin
    if (s1_fresh_q) begin
      res_a = s1_rfva_q ? s1_rfa_q : 32'h0;
      res_b = s1_rfvb_q ? s1_rfb_q : 32'h0;
      // The write that retired at the read edge is not in the read data yet.
      if (wb_vld_q && (wb_idx_q == s1_rs)) begin
        res_a = wb_val_q;
      end
      if (wb_vld_q && (wb_idx_q == s1_rt)) begin
        res_b = wb_val_q;
      end
    end else begin
      res_a = s1_a_q;
      res_b = s1_b_q;
    end
    if (s3_vld_q && s3_wr_q && (s3_rt_q == s1_rs)) begin
      res_a = s3_val;
    end
    if (s3_vld_q && s3_wr_q && (s3_rt_q == s1_rt)) begin
      res_b = s3_val;
    end
    if (s2_vld_q && s2_wr_q && (s2_rt_q == s1_rs)) begin
      res_a = s2_alu_q;
    end
    if (s2_vld_q && s2_wr_q && (s2_rt_q == s1_rt)) begin
      res_b = s2_alu_q;
    end
  end

  always_comb begin
    s1_alu   = 32'h0;
    s1_wr    = 1'b0;
    s1_taken = 1'b0;
    s1_badop = 1'b0;
    s1_ld    = 1'b0;
    s1_st    = 1'b0;
    s1_sgn   = 1'b0;
    s1_sz    = SZ_BYTE;
    case (mipsie_pkg::opcode_e'(s1_iw_q[31:26]))
      mipsie_pkg::OP_ADDI, mipsie_pkg::OP_ADDIU: begin
        s1_alu = res_a + s1_simm;
        s1_wr  = 1'b1;
      end
      mipsie_pkg::OP_SLTI: begin
        s1_alu = {31'h0, $signed(res_a) < $signed(s1_simm)};
        s1_wr  = 1'b1;
      end
      mipsie_pkg::OP_SLTIU: begin
        s1_alu = {31'h0, res_a < s1_simm};
        s1_wr  = 1'b1;
      end
      mipsie_pkg::OP_ANDI: begin
        s1_alu = res_a & s1_zimm;
        s1_wr  = 1'b1;
      end
      mipsie_pkg::OP_ORI: begin
        s1_alu = res_a | s1_zimm;
        s1_wr  = 1'b1;
      end
      mipsie_pkg::OP_XORI: begin
        s1_alu = res_a ^ s1_zimm;
        s1_wr  = 1'b1;
      end
      mipsie_pkg::OP_LUI: begin
        s1_alu = {s1_imm, 16'h0000};
        s1_wr  = 1'b1;
      end
      mipsie_pkg::OP_BEQ:  s1_taken = (res_a == res_b);
      mipsie_pkg::OP_BNE:  s1_taken = (res_a != res_b);
      mipsie_pkg::OP_BLEZ: s1_taken = res_a[31] || (res_a == 32'h0);
      mipsie_pkg::OP_BGTZ: s1_taken = !res_a[31] && (res_a != 32'h0);
      mipsie_pkg::OP_REGIMM: begin
        if (s1_rt == mipsie_pkg::RT_BLTZ) begin
          s1_taken = res_a[31];
        end else if (s1_rt == mipsie_pkg::RT_BGEZ) begin
          s1_taken = !res_a[31];
        end else begin
          s1_badop = 1'b1;
        end
      end
      mipsie_pkg::OP_LB: begin
        s1_ld  = 1'b1;
        s1_sgn = 1'b1;
      end
      mipsie_pkg::OP_LBU: s1_ld = 1'b1;
      mipsie_pkg::OP_LH: begin
        s1_ld  = 1'b1;
        s1_sgn = 1'b1;
        s1_sz  = SZ_HALF;
      end
      mipsie_pkg::OP_LHU: begin
        s1_ld = 1'b1;
        s1_sz = SZ_HALF;
      end
      mipsie_pkg::OP_LW: begin
        s1_ld = 1'b1;
        s1_sz = SZ_WORD;
      end
      mipsie_pkg::OP_SB: s1_st = 1'b1;
      mipsie_pkg::OP_SH: begin
        s1_st = 1'b1;
        s1_sz = SZ_HALF;
      end
      mipsie_pkg::OP_SW: begin
        s1_st = 1'b1;
        s1_sz = SZ_WORD;
      end
      default: s1_badop = 1'b1;
    endcase
  end

  assign s1_off = res_a + s1_disp_q;
  assign s1_npc = s1_taken ? s1_target_q : s1_pc_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_rt_q    <= s1_rt;
      s2_alu_q   <= s1_alu;
      s2_wr_q    <= s1_wr && (s1_rt != 5'd0);
      s2_ld_q    <= s1_ld;
      s2_st_q    <= s1_st;
      s2_sgn_q   <= s1_sgn;
      s2_sz_q    <= s1_sz;
      s2_off_q   <= s1_off;
      s2_b_q     <= res_b;
      s2_npc_q   <= s1_npc;
      s2_badop_q <= s1_badop;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: range check and access to the four byte-lane banks.
  // Byte offset o lives in bank o[1:0] at row o>>2.
  always_comb begin
    case (s2_sz_q)
      SZ_BYTE: s2_in_range = (s2_off_q <= LIM_BYTE);
      SZ_HALF: s2_in_range = (s2_off_q <= LIM_HALF);
      default: s2_in_range = (s2_off_q <= LIM_WORD);
    endcase
  end

  assign s2_lo      = s2_off_q[1:0];
  assign s2_row     = s2_off_q[RW+1:2];
  assign s2_row_inc = s2_row + RW'(1);

  always_comb begin
    logic [1:0] rel;
    logic       used;
    for (int k = 0; k < 4; k++) begin
      rel = 2'(k) - s2_lo;
      case (s2_sz_q)
        SZ_BYTE: used = (rel == 2'd0);
        SZ_HALF: used = (rel <= 2'd1);
        default: used = 1'b1;
      endcase
      // Lanes below the start lane wrap into the next row.
      bank_row[k] = (2'(k) < s2_lo) ? s2_row_inc : s2_row;
      if (clr_q) begin
        bank_we[k]    = 1'b1;
        bank_waddr[k] = clr_row_q;
        bank_wdata[k] = 8'h00;
      end else begin
        bank_we[k]    = s2_adv && s2_st_q && s2_in_range && used;
        bank_waddr[k] = bank_row[k];
        bank_wdata[k] = s2_b_q[{rel, 3'b000} +: 8];
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0] bank_mem [ROWS];
    always_ff @(posedge clk_i) begin
      if (bank_we[k]) begin
        bank_mem[bank_waddr[k]] <= bank_wdata[k];
      end
      if (s2_adv) begin
        rd_q[k] <= bank_mem[bank_row[k]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_rt_q  <= s2_rt_q;
      s3_alu_q <= s2_alu_q;
      s3_npc_q <= s2_npc_q;
      s3_ld_q  <= s2_ld_q;
      s3_wr_q  <= s2_wr_q || (s2_ld_q && s2_in_range && (s2_rt_q != 5'd0));
      s3_mw_q  <= s2_st_q && s2_in_range;
      s3_sgn_q <= s2_sgn_q;
      s3_sz_q  <= s2_sz_q;
      s3_lo_q  <= s2_lo;
      if (s2_badop_q) begin
        s3_status_q <= mipsie_pkg::ST_BADOP;
      end else if ((s2_ld_q || s2_st_q) && !s2_in_range) begin
        s3_status_q <= mipsie_pkg::ST_BADADDR;
      end else begin
        s3_status_q <= mipsie_pkg::ST_OK;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: align the load data and retire into the output register.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      s3_word[8*j +: 8] = rd_q[s3_lo_q + 2'(j)];
    end
    case (s3_sz_q)
      SZ_BYTE: s3_ldv = {{24{s3_sgn_q && s3_word[7]}}, s3_word[7:0]};
      SZ_HALF: s3_ldv = {{16{s3_sgn_q && s3_word[15]}}, s3_word[15:0]};
      default: s3_ldv = s3_word;
    endcase
    s3_val = s3_ld_q ? s3_ldv : s3_alu_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_npc_q    <= s3_npc_q;
      out_wr_q     <= s3_wr_q;
      out_idx_q    <= s3_wr_q ? s3_rt_q : 5'd0;
      out_val_q    <= s3_wr_q ? s3_val : 32'h0;
      out_mw_q     <= s3_mw_q;
      out_status_q <= s3_status_q;
    end
  end

  assign m_axis_tdata = {7'd0, out_status_q, out_mw_q, out_val_q, out_idx_q, out_wr_q,
                         out_npc_q};

endmodule

[rtl/mipsie_checker.sv]
`include "mips_itype_execute_assert.svh"

module mipsie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  logic       reg_written, mem_written;
  logic [4:0] dest_index;
  logic [31:0] dest_value;
  logic [1:0] status;

  assign reg_written = m_axis_tdata[32];
  assign dest_index  = m_axis_tdata[37:33];
  assign dest_value  = m_axis_tdata[69:38];
  assign mem_written = m_axis_tdata[70];
  assign status      = m_axis_tdata[72:71];

  `MIE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  `MIE_ASSERT_NOW(a_err_no_effect, clk_i, rst_ni, m_axis_tvalid && (status != mipsie_pkg::ST_OK), !reg_written && !mem_written, "failed instruction reports a write")

  `MIE_ASSERT_NOW(a_no_wr_zero, clk_i, rst_ni, m_axis_tvalid && !reg_written, (dest_index == 5'd0) && (dest_value == 32'h0), "destination fields set without a register write")

  `MIE_ASSERT_NOW(a_wr_excl, clk_i, rst_ni, m_axis_tvalid && reg_written, (dest_index != 5'd0) && !mem_written, "register write to r0 or together with a store")

endmodule

bind mips_itype_execute mipsie_checker u_mipsie_checker (.*);
